// ----- rtl/tma_pkg.sv -----
// Shared types and constants for the token mutex arbiter.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package tma_pkg;

   localparam int SITES_DEF     = 4;
   localparam int SEQ_WIDTH_DEF = 16;
   localparam int SITE_WIDTH    = 2;
   localparam int CFG_WIDTH     = 2;

   localparam logic [CFG_WIDTH-1:0] INIT_HOLDER_RESET = 2'd1;

   localparam logic ACTION_REQUEST = 1'b0;
   localparam logic ACTION_RELEASE = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_IGNORED = 1'b1;

   typedef struct packed {
      logic                  action;
      logic [SITE_WIDTH-1:0] site;
   } req_beat_type;

   typedef struct packed {
      logic                  granted;
      logic [SITE_WIDTH-1:0] granted_site;
      logic [SITE_WIDTH-1:0] token_site;
      logic                  section_busy;
      logic                  status;
   } rsp_beat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_FINISH,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/tma_req_if.sv -----
// Request channel of the token mutex arbiter: valid, ready and one beat.
// Depends on tma_pkg for the beat type.
`timescale 1ns / 1ps

interface tma_req_if;
   import tma_pkg::*;

   logic         valid;
   logic         ready;
   req_beat_type beat;

   modport source (output valid, output beat, input ready);
   modport sink (input valid, input beat, output ready);
endinterface

// ----- rtl/tma_rsp_if.sv -----
// Response channel of the token mutex arbiter: valid, ready and one beat.
// Depends on tma_pkg for the beat type.
`timescale 1ns / 1ps

interface tma_rsp_if;
   import tma_pkg::*;

   logic         valid;
   logic         ready;
   rsp_beat_type beat;

   modport source (output valid, output beat, input ready);
   modport sink (input valid, input beat, output ready);
endinterface

// ----- rtl/token_mutex_arbiter_core.sv -----
// Top level of the token mutex arbiter: sequencer, sequence-number memory,
// last-served memory and wait queue. Uses tma_pkg, tma_req_if, tma_rsp_if,
// tma_vmem and tma_queue.
//
// The block arbitrates a single token among SITES sites in the manner of
// Suzuki-Kasami: a request bumps the site's sequence number and spreads it to
// every site's view, and a release by the holder queues all outstanding sites
// in ascending order and hands the token to the queue head. Each beat returns
// exactly one response beat. For a request or a valid release the sequencer
// walks the per-site sequence-number memory one entry per cycle through its
// single read port; an ignored beat, or a request by the site already in
// the section, skips the walk. A response waiting on a stalled output does
// not stop the next request beat from being taken. There is no clearing pass
// after reset: every memory entry carries a valid bit. Writes to the
// initial-holder register move the token only before the first beat after
// reset.
`timescale 1ns / 1ps

module token_mutex_arbiter_core #(
   parameter int SITES     = tma_pkg::SITES_DEF,
   parameter int SEQ_WIDTH = tma_pkg::SEQ_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   tma_req_if.sink                      req_chan,
   tma_rsp_if.source                    rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [tma_pkg::CFG_WIDTH-1:0] csr_wr_data
);
   import tma_pkg::*;

   localparam int SW = $clog2(SITES);
   localparam int CW = $clog2(SITES + 1);
   localparam int AW = $clog2(SITES * SITES);

   function automatic logic [AW-1:0] rn_addr(input logic [SW-1:0] row,
                                             input logic [SW-1:0] col);
      rn_addr = AW'(32'(row) * SITES + 32'(col));
   endfunction

   function automatic logic [SITE_WIDTH-1:0] site_mod(input logic [CFG_WIDTH-1:0] v);
      if (32'(v) >= SITES) begin
         site_mod = SITE_WIDTH'(32'(v) - SITES);
      end else begin
         site_mod = SITE_WIDTH'(v);
      end
   endfunction

   function automatic logic seq_newer(input logic [SEQ_WIDTH-1:0] cand,
                                      input logic [SEQ_WIDTH-1:0] old);
      logic [SEQ_WIDTH-1:0] d;
      d         = cand - old;
      seq_newer = (d != '0) && !d[SEQ_WIDTH-1];
   endfunction

   state_type              state_ff, state_in;
   logic                   action_ff, action_in;
   logic [SITE_WIDTH-1:0]  site_ff, site_in;
   logic [SW-1:0]          j_ff, j_in;
   logic [SEQ_WIDTH-1:0]   sn_ff, sn_in;
   logic [SEQ_WIDTH-1:0]   lsv_ff, lsv_in;
   logic                   outst_ff, outst_in;
   logic [SITE_WIDTH-1:0]  holder_ff, holder_in;
   logic                   inside_ff, inside_in;
   logic                   fresh_ff, fresh_in;
   logic [CFG_WIDTH-1:0]   init_ff, init_in;
   rsp_beat_type           res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_beat_type           rsp_beat_ff, rsp_beat_in;

   logic [AW-1:0]          rn_raddr, rn_waddr;
   logic [SEQ_WIDTH-1:0]   rn_rdata, rn_wdata;
   logic                   rn_we;
   logic [SW-1:0]          ls_raddr, ls_waddr;
   logic [SEQ_WIDTH-1:0]   ls_rdata, ls_wdata;
   logic                   ls_we;

   logic                   q_push, q_pop;
   logic [SW-1:0]          q_head;
   logic [CW-1:0]          q_count;
   logic [SITES-1:0]       q_queued;

   logic [SW-1:0]          req_idx, site_idx, j_next;
   logic [SEQ_WIDTH-1:0]   cur;
   logic                   is_last;

   tma_vmem #(.DEPTH(SITES * SITES), .WIDTH(SEQ_WIDTH)) u_seq_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rn_raddr),
      .rd_data (rn_rdata),
      .wr_en   (rn_we),
      .wr_addr (rn_waddr),
      .wr_data (rn_wdata)
   );

   tma_vmem #(.DEPTH(SITES), .WIDTH(SEQ_WIDTH)) u_served_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (ls_raddr),
      .rd_data (ls_rdata),
      .wr_en   (ls_we),
      .wr_addr (ls_waddr),
      .wr_data (ls_wdata)
   );

   tma_queue #(.SITES(SITES)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_site (j_ff),
      .pop       (q_pop),
      .head_site (q_head),
      .count     (q_count),
      .queued    (q_queued)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         holder_ff    <= site_mod(INIT_HOLDER_RESET);
         inside_ff    <= 1'b0;
         fresh_ff     <= 1'b1;
         init_ff      <= INIT_HOLDER_RESET;
         rsp_valid_ff <= 1'b0;
         outst_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         holder_ff    <= holder_in;
         inside_ff    <= inside_in;
         fresh_ff     <= fresh_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         outst_ff     <= outst_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      site_ff     <= site_in;
      j_ff        <= j_in;
      sn_ff       <= sn_in;
      lsv_ff      <= lsv_in;
      res_ff      <= res_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.beat  = rsp_beat_ff;

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      site_in      = site_ff;
      j_in         = j_ff;
      sn_in        = sn_ff;
      lsv_in       = lsv_ff;
      outst_in     = outst_ff;
      holder_in    = holder_ff;
      inside_in    = inside_ff;
      fresh_in     = fresh_ff;
      init_in      = init_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_beat_in  = rsp_beat_ff;

      req_idx  = SW'(req_chan.beat.site);
      site_idx = SW'(site_ff);
      j_next   = j_ff + SW'(1);
      is_last  = (32'(j_ff) == SITES - 1);
      cur      = rn_rdata;

      rn_raddr = '0;
      rn_we    = 1'b0;
      rn_waddr = rn_addr(site_idx, site_idx);
      rn_wdata = sn_ff;
      ls_raddr = '0;
      ls_we    = 1'b0;
      ls_waddr = site_idx;
      ls_wdata = rn_rdata;
      q_push   = 1'b0;
      q_pop    = 1'b0;

      if (csr_wr_en) begin
         init_in = csr_wr_data;
         if (fresh_ff) begin
            holder_in = site_mod(csr_wr_data);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               action_in = req_chan.beat.action;
               site_in   = req_chan.beat.site;
               fresh_in  = 1'b0;
               j_in      = '0;
               outst_in  = 1'b0;
               res_in    = '{granted: 1'b0, granted_site: '0, token_site: holder_ff,
                             section_busy: inside_ff, status: STATUS_OK};
               if (32'(req_chan.beat.site) >= SITES) begin
                  state_in = ST_DONE;
               end else if (req_chan.beat.action == ACTION_REQUEST) begin
                  if (req_chan.beat.site == holder_ff && inside_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     rn_raddr = rn_addr(req_idx, req_idx);
                     ls_raddr = req_idx;
                     state_in = ST_FETCH;
                  end
               end else begin
                  if (req_chan.beat.site != holder_ff || !inside_ff) begin
                     res_in.status = STATUS_IGNORED;
                     state_in      = ST_DONE;
                  end else begin
                     rn_raddr = rn_addr(req_idx, req_idx);
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            if (action_ff == ACTION_REQUEST) begin
               sn_in    = rn_rdata + SEQ_WIDTH'(1);
               rn_we    = 1'b1;
               rn_wdata = sn_in;
               lsv_in   = ls_rdata;
               rn_raddr = rn_addr('0, site_idx);
            end else begin
               ls_we    = 1'b1;
               rn_raddr = rn_addr(site_idx, '0);
               ls_raddr = '0;
            end
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (action_ff == ACTION_REQUEST) begin
               if (j_ff != site_idx) begin
                  if (seq_newer(sn_ff, rn_rdata)) begin
                     rn_we    = 1'b1;
                     rn_waddr = rn_addr(j_ff, site_idx);
                     cur      = sn_ff;
                  end
                  if (32'(j_ff) == 32'(holder_ff)) begin
                     outst_in = (cur == lsv_ff + SEQ_WIDTH'(1));
                  end
               end
               if (!is_last) begin
                  rn_raddr = rn_addr(j_next, site_idx);
               end
            end else begin
               if (j_ff != site_idx && rn_rdata == ls_rdata + SEQ_WIDTH'(1) &&
                   !q_queued[j_ff] && 32'(q_count) < SITES) begin
                  q_push = 1'b1;
               end
               if (!is_last) begin
                  rn_raddr = rn_addr(site_idx, j_next);
                  ls_raddr = j_next;
               end
            end
            if (is_last) begin
               state_in = ST_FINISH;
            end else begin
               j_in = j_next;
            end
         end
         ST_FINISH: begin
            res_in.granted      = 1'b0;
            res_in.granted_site = '0;
            if (action_ff == ACTION_REQUEST) begin
               if (site_ff == holder_ff) begin
                  inside_in           = 1'b1;
                  res_in.granted      = 1'b1;
                  res_in.granted_site = site_ff;
               end else if (!inside_ff && outst_ff) begin
                  holder_in           = site_ff;
                  inside_in           = 1'b1;
                  res_in.granted      = 1'b1;
                  res_in.granted_site = site_ff;
               end
            end else begin
               inside_in = 1'b0;
               if (q_count != '0) begin
                  q_pop               = 1'b1;
                  holder_in           = SITE_WIDTH'(q_head);
                  inside_in           = 1'b1;
                  res_in.granted      = 1'b1;
                  res_in.granted_site = SITE_WIDTH'(q_head);
               end
            end
            res_in.token_site   = holder_in;
            res_in.section_busy = inside_in;
            res_in.status       = STATUS_OK;
            state_in            = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_beat_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/tma_vmem.sv -----
// Synchronous one-read one-write memory with a valid bit per entry.
// Entries never written read as zero; read data is registered. Uses tma_pkg.
`timescale 1ns / 1ps

module tma_vmem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);
   import tma_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] data_ff;
   logic             hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         hit_ff <= valid_ff[rd_addr];
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

// ----- rtl/tma_queue.sv -----
// Ring queue of waiting sites that travels with the token, plus a mask of
// the sites currently queued. Uses tma_pkg.
`timescale 1ns / 1ps

module tma_queue #(
   parameter int SITES = tma_pkg::SITES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [$clog2(SITES)-1:0]   push_site,
   input  logic                       pop,
   output logic [$clog2(SITES)-1:0]   head_site,
   output logic [$clog2(SITES+1)-1:0] count,
   output logic [SITES-1:0]           queued
);
   import tma_pkg::*;

   localparam int SW = $clog2(SITES);
   localparam int CW = $clog2(SITES + 1);

   logic [SW-1:0] entries_ff [SITES];
   logic [SW-1:0] head_ff;
   logic [CW-1:0] count_ff;
   logic [SITES-1:0] queued_ff;
   logic [SW+1:0] tail_sum;
   logic [SW-1:0] tail;

   always_comb begin
      tail_sum = (SW+2)'(head_ff) + (SW+2)'(count_ff);
      if (32'(tail_sum) >= SITES) begin
         tail = SW'(32'(tail_sum) - SITES);
      end else begin
         tail = SW'(tail_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[tail] <= push_site;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         queued_ff <= '0;
      end else if (push) begin
         count_ff            <= count_ff + CW'(1);
         queued_ff[push_site] <= 1'b1;
      end else if (pop) begin
         count_ff <= count_ff - CW'(1);
         queued_ff[entries_ff[head_ff]] <= 1'b0;
         if (32'(head_ff) == SITES - 1) begin
            head_ff <= '0;
         end else begin
            head_ff <= head_ff + SW'(1);
         end
      end
   end

   assign head_site = entries_ff[head_ff];
   assign count     = count_ff;
   assign queued    = queued_ff;

endmodule

// ----- dv/token_mutex_arbiter_core_test.sv -----
// Self-checking testbench for token_mutex_arbiter_core with a scoreboard class.
// Depends on tma_pkg, tma_req_if, tma_rsp_if and the arbiter RTL.
`timescale 1ns / 1ps

module token_mutex_arbiter_core_test;
   import tma_pkg::*;

   localparam int SITES          = SITES_DEF;
   localparam int SEQ_W          = SEQ_WIDTH_DEF;
   localparam int SETTLE_CYCLES  = SITES + 8;
   localparam int STARVE_CYCLES  = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PRINT_LIMIT    = 40;
   localparam int BURST_REQUESTS = 20;

   typedef logic [SEQ_W-1:0] seq_type;

   class token_grant_book;
      seq_type         seq_view [SITES][SITES];
      seq_type         served [SITES];
      logic [1:0]      waitq [SITES];
      int              q_head;
      int              q_len;
      logic [1:0]      holder;
      logic [1:0]      holder_cfg;
      bit              busy;
      bit              fresh;
      rsp_beat_type    expected_grants [$];
      int              errors;
      int              grants;
      int              ignored;
      int              checked;

      function new();
         for (int j = 0; j < SITES; j++) begin
            served[j] = '0;
            waitq[j] = '0;
            for (int i = 0; i < SITES; i++) begin
               seq_view[j][i] = '0;
            end
         end
         q_head = 0;
         q_len = 0;
         holder_cfg = INIT_HOLDER_RESET;
         holder = SITE_WIDTH'(int'(INIT_HOLDER_RESET) % SITES);
         busy = 1'b0;
         fresh = 1'b1;
      endfunction

      function void write_holder_cfg(logic [CFG_WIDTH-1:0] v);
         holder_cfg = v;
         if (fresh) begin
            holder = SITE_WIDTH'(int'(v) % SITES);
         end
      endfunction

      function bit newer(seq_type cand, seq_type old);
         seq_type d;
         d = cand - old;
         return (d != '0) && (d[SEQ_W-1] == 1'b0);
      endfunction

      function bit outstanding(int viewer, int s);
         return seq_view[viewer][s] == seq_type'(served[s] + 1'b1);
      endfunction

      function bit queued(int s);
         for (int k = 0; k < q_len; k++) begin
            if (int'(waitq[(q_head + k) % SITES]) == s) begin
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function bit site_idle(int s);
         return !outstanding(s, s) && !(s == int'(holder) && busy);
      endfunction

      function int pending();
         return expected_grants.size();
      endfunction

      function void log_beat(req_beat_type b);
         rsp_beat_type want;
         seq_type sn;
         int s;
         s = int'(b.site);
         fresh = 1'b0;
         want = '0;
         want.status = STATUS_OK;
         if (b.action == ACTION_REQUEST) begin
            if (!(b.site == holder && busy)) begin
               sn = seq_view[s][s] + 1'b1;
               seq_view[s][s] = sn;
               for (int j = 0; j < SITES; j++) begin
                  if (j != s && newer(sn, seq_view[j][s])) begin
                     seq_view[j][s] = sn;
                  end
               end
               if (b.site == holder) begin
                  busy = 1'b1;
                  want.granted = 1'b1;
                  want.granted_site = b.site;
               end else if (!busy && outstanding(int'(holder), s)) begin
                  holder = b.site;
                  busy = 1'b1;
                  want.granted = 1'b1;
                  want.granted_site = b.site;
               end
            end
         end else if (b.site != holder || !busy) begin
            want.status = STATUS_IGNORED;
            ignored++;
         end else begin
            served[s] = seq_view[s][s];
            for (int j = 0; j < SITES; j++) begin
               if (outstanding(s, j) && !queued(j) && q_len < SITES) begin
                  waitq[(q_head + q_len) % SITES] = SITE_WIDTH'(j);
                  q_len++;
               end
            end
            busy = 1'b0;
            if (q_len > 0) begin
               holder = waitq[q_head];
               q_head = (q_head + 1) % SITES;
               q_len--;
               busy = 1'b1;
               want.granted = 1'b1;
               want.granted_site = holder;
            end
         end
         if (want.granted) begin
            grants++;
         end
         want.token_site = holder;
         want.section_busy = busy;
         expected_grants.push_back(want);
      endfunction

      function void flag(string field, logic [1:0] want, logic [1:0] seen);
         errors++;
         if (errors <= PRINT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
         end
      endfunction

      function void check_grant(rsp_beat_type got);
         rsp_beat_type want;
         checked++;
         if (expected_grants.size() == 0) begin
            errors++;
            if (errors <= PRINT_LIMIT) begin
               $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
            end
            return;
         end
         want = expected_grants.pop_front();
         if (got.granted !== want.granted) begin
            flag("granted", want.granted, got.granted);
         end
         if (got.granted_site !== want.granted_site) begin
            flag("granted_site", want.granted_site, got.granted_site);
         end
         if (got.token_site !== want.token_site) begin
            flag("token_site", want.token_site, got.token_site);
         end
         if (got.section_busy !== want.section_busy) begin
            flag("section_busy", want.section_busy, got.section_busy);
         end
         if (got.status !== want.status) begin
            flag("status", want.status, got.status);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CFG_WIDTH-1:0] csr_wr_data;

   tma_req_if req_bus ();
   tma_rsp_if rsp_bus ();

   token_grant_book book;
   bit  no_idle;
   bit  starve_rsp;
   int  starve_count;
   int  beats_sent;
   int  burst_requests;
   int  holder_writes;
   int  quiet_cycles;

   token_mutex_arbiter_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus.sink),
      .rsp_chan    (rsp_bus.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic req_beat_type beat_of(logic action, int s);
      req_beat_type b;
      b.action = action;
      b.site = SITE_WIDTH'(s);
      return b;
   endfunction

   function automatic req_beat_type pick_item(int broken_pct);
      req_beat_type b;
      int idle_sites [$];
      int r;
      r = $urandom_range(0, 99);
      b.site = SITE_WIDTH'($urandom_range(0, SITES - 1));
      b.action = $urandom_range(0, 1) ? ACTION_RELEASE : ACTION_REQUEST;
      if (r < broken_pct) begin
         return b;
      end
      if (r < broken_pct + 12) begin
         if (book.busy && $urandom_range(0, 1) == 1) begin
            b.action = ACTION_REQUEST;
            b.site = book.holder;
         end else begin
            b.action = ACTION_RELEASE;
            while (book.busy && b.site == book.holder) begin
               b.site = SITE_WIDTH'($urandom_range(0, SITES - 1));
            end
         end
         return b;
      end
      for (int s = 0; s < SITES; s++) begin
         if (book.site_idle(s)) begin
            idle_sites.push_back(s);
         end
      end
      if (book.busy && (idle_sites.size() == 0 || $urandom_range(0, 2) == 0)) begin
         b.action = ACTION_RELEASE;
         b.site = book.holder;
      end else if (idle_sites.size() > 0) begin
         b.action = ACTION_REQUEST;
         b.site = SITE_WIDTH'(idle_sites[$urandom_range(0, idle_sites.size() - 1)]);
      end
      return b;
   endfunction

   task automatic send_beat(input req_beat_type b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.beat <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      book.log_beat(b);
      beats_sent++;
   endtask

   task automatic run_random(int count, int broken_pct);
      repeat (count) send_beat(pick_item(broken_pct));
   endtask

   task automatic write_holder(logic [CFG_WIDTH-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      book.write_holder_cfg(v);
      holder_writes++;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The chosen site keeps requesting while the token stays busy elsewhere,
   // so its own number runs well past the last one served.
   task automatic run_burst();
      int w;
      if (!book.busy) begin
         send_beat(beat_of(ACTION_REQUEST, int'(book.holder)));
      end
      w = (int'(book.holder) + 1) % SITES;
      repeat (BURST_REQUESTS) begin
         send_beat(beat_of(ACTION_REQUEST, w));
         burst_requests++;
      end
      send_beat(beat_of(ACTION_RELEASE, int'(book.holder)));
      send_beat(beat_of(ACTION_RELEASE, int'(book.holder)));
   endtask

   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (starve_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (STARVE_CYCLES) @(posedge clock);
            starve_rsp = 1'b0;
            starve_count++;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         book.check_grant(rsp_bus.beat);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("** token_mutex_arbiter_core: FAILED **");
         $finish;
      end
   end

   initial begin
      book = new();
      no_idle = 1'b0;
      starve_rsp = 1'b0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.beat <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Before the first beat every write moves the token; the last one wins.
      write_holder(2'd0);
      write_holder(2'd3);

      send_beat(beat_of(ACTION_RELEASE, 3));
      send_beat(beat_of(ACTION_RELEASE, 0));
      send_beat(beat_of(ACTION_REQUEST, 3));
      send_beat(beat_of(ACTION_REQUEST, 3));
      send_beat(beat_of(ACTION_REQUEST, 0));
      send_beat(beat_of(ACTION_REQUEST, 1));
      send_beat(beat_of(ACTION_REQUEST, 2));
      send_beat(beat_of(ACTION_RELEASE, 1));
      send_beat(beat_of(ACTION_RELEASE, 3));
      send_beat(beat_of(ACTION_RELEASE, 0));
      send_beat(beat_of(ACTION_REQUEST, 3));
      send_beat(beat_of(ACTION_RELEASE, 1));
      send_beat(beat_of(ACTION_RELEASE, 2));
      send_beat(beat_of(ACTION_RELEASE, 3));
      send_beat(beat_of(ACTION_REQUEST, 0));
      send_beat(beat_of(ACTION_REQUEST, 2));
      send_beat(beat_of(ACTION_RELEASE, 0));
      send_beat(beat_of(ACTION_RELEASE, 2));
      send_beat(beat_of(ACTION_RELEASE, 2));
      send_beat(beat_of(ACTION_REQUEST, 1));
      send_beat(beat_of(ACTION_RELEASE, 1));
      drain();

      // Later writes only change the stored value.
      write_holder(2'd1);
      no_idle = 1'b1;
      run_random(200, 0);
      no_idle = 1'b0;
      drain();

      write_holder(2'd2);
      starve_rsp = 1'b1;
      run_random(650, 0);
      drain();

      write_holder(CFG_WIDTH'($urandom_range(0, 3)));
      no_idle = 1'b1;
      run_burst();
      no_idle = 1'b0;
      drain();

      write_holder(2'd3);
      run_random(740, 0);
      run_random(60, 40);
      drain();

      $display("Sent %0d beats: %0d grants, %0d ignored releases, %0d results checked.",
               beats_sent, book.grants, book.ignored, book.checked);
      $display("Repeated-request burst of %0d beats; %0d holder writes, %0d long output stalls.",
               burst_requests, holder_writes, starve_count);
      if (book.errors == 0) begin
         $display("** token_mutex_arbiter_core: PASSED **");
      end else begin
         $display("** token_mutex_arbiter_core: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/tma_pkg.sv
rtl/tma_req_if.sv
rtl/tma_rsp_if.sv
rtl/tma_vmem.sv
rtl/tma_queue.sv
rtl/token_mutex_arbiter_core.sv
dv/token_mutex_arbiter_core_test.sv
